@@ rtl/rffp_pkg.sv @@
// Shared types, codes and constants for the range/flow frame parser.
// The CRC-8 DVB-S2 byte step lives here as a function.
// No dependencies.
package rffp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_BYTE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_BYTE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_ID       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ID        = 3'd5;

  // Parser phases
  localparam logic [4:0] PH_HDR_FIRST   = 5'd0;
  localparam logic [4:0] PH_ID          = 5'd4;
  localparam logic [4:0] PH_FIRST_DATA  = 5'd5;
  localparam logic [4:0] PH_CHK_RANGE   = 5'd13;
  localparam logic [4:0] PH_CHK_FLOW    = 5'd17;

  // CRC-8 DVB-S2
  localparam logic [7:0] CRC_POLY         = 8'hD5;
  localparam logic [7:0] CRC_TOP          = 8'h80;
  localparam logic [7:0] CRC_PRESET_RANGE = 8'hD5;
  localparam logic [7:0] CRC_PRESET_FLOW  = 8'h7F;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_RANGE = 2'd1,
    KIND_FLOW  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] direction_byte;
    logic [7:0] flag_byte;
    logic [7:0] range_id;
    logic [7:0] flow_id;
  } cfg_t;

  typedef struct packed {
    logic        frame_kind;
    logic        crc_ok;
    logic [7:0]  range_quality;
    logic [31:0] range_mm;
    logic [7:0]  surface_quality;
    logic [31:0] motion_x;
    logic [31:0] motion_y;
  } res_t;

  // One byte through the CRC, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_TOP) != 8'd0) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

@@ rtl/rffp_parser.sv @@
// Frame parser core: header/id match, payload capture, running CRC, held values.
// Processes one byte per enabled cycle. Depends on rffp_pkg.
module rffp_parser #(
  parameter int unsigned PAYLOAD_DEPTH = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        byte_i,
  input  rffp_pkg::cfg_t    cfg_i,
  output logic              emit_o,
  output rffp_pkg::res_t    res_o
);

  localparam int unsigned IDX_W  = $clog2(PAYLOAD_DEPTH);
  localparam logic [4:0]  DEPTH5 = 5'(PAYLOAD_DEPTH);

  logic [4:0]       phase_r, phase_nxt;
  rffp_pkg::kind_t  kind_r, kind_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       store_r [PAYLOAD_DEPTH];
  logic [31:0]      range_r, range_nxt;
  logic [7:0]       rqual_r, rqual_nxt;
  logic [7:0]       squal_r, squal_nxt;
  logic [31:0]      mx_r, mx_nxt;
  logic [31:0]      my_r, my_nxt;

  logic             st_we;
  logic [4:0]       st_off;
  logic [7:0]       want;
  logic [4:0]       chk_ph;
  logic             kind_ok;
  logic             ok;

  assign st_off = phase_r - rffp_pkg::PH_FIRST_DATA;

  always_comb begin
    unique case (phase_r[1:0])
      2'd0:    want = cfg_i.header_first;
      2'd1:    want = cfg_i.header_second;
      2'd2:    want = cfg_i.direction_byte;
      default: want = cfg_i.flag_byte;
    endcase
  end

  always_comb begin
    unique case (kind_r)
      rffp_pkg::KIND_RANGE: begin
        chk_ph  = rffp_pkg::PH_CHK_RANGE;
        kind_ok = 1'b1;
      end
      rffp_pkg::KIND_FLOW: begin
        chk_ph  = rffp_pkg::PH_CHK_FLOW;
        kind_ok = 1'b1;
      end
      default: begin
        chk_ph  = rffp_pkg::PH_CHK_RANGE;
        kind_ok = 1'b0;
      end
    endcase
  end

  assign ok = (crc_r == byte_i);

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    crc_nxt   = crc_r;
    range_nxt = range_r;
    rqual_nxt = rqual_r;
    squal_nxt = squal_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    st_we     = 1'b0;
    emit_o    = 1'b0;
    priority if (phase_r < rffp_pkg::PH_ID) begin
      if (byte_i == want) begin
        phase_nxt = phase_r + 5'd1;
      end else begin
        phase_nxt = rffp_pkg::PH_HDR_FIRST;
        kind_nxt  = rffp_pkg::KIND_NONE;
      end
    end else if (phase_r == rffp_pkg::PH_ID) begin
      priority if (byte_i == cfg_i.range_id) begin
        kind_nxt  = rffp_pkg::KIND_RANGE;
        crc_nxt   = rffp_pkg::CRC_PRESET_RANGE;
        phase_nxt = rffp_pkg::PH_FIRST_DATA;
      end else if (byte_i == cfg_i.flow_id) begin
        kind_nxt  = rffp_pkg::KIND_FLOW;
        crc_nxt   = rffp_pkg::CRC_PRESET_FLOW;
        phase_nxt = rffp_pkg::PH_FIRST_DATA;
      end else begin
        phase_nxt = rffp_pkg::PH_HDR_FIRST;
        kind_nxt  = rffp_pkg::KIND_NONE;
      end
    end else if (!kind_ok || phase_r > chk_ph) begin
      phase_nxt = rffp_pkg::PH_HDR_FIRST;
      kind_nxt  = rffp_pkg::KIND_NONE;
    end else if (phase_r < chk_ph) begin
      st_we     = (st_off < DEPTH5);
      crc_nxt   = rffp_pkg::crc8_step(crc_r, byte_i);
      phase_nxt = phase_r + 5'd1;
    end else begin
      emit_o = 1'b1;
      if (ok) begin
        if (kind_r == rffp_pkg::KIND_RANGE) begin
          rqual_nxt = store_r[3];
          range_nxt = {store_r[7], store_r[6], store_r[5], store_r[4]};
        end else begin
          squal_nxt = store_r[3];
          mx_nxt    = {store_r[7], store_r[6], store_r[5], store_r[4]};
          my_nxt    = {store_r[11], store_r[10], store_r[9], store_r[8]};
        end
      end
      phase_nxt = rffp_pkg::PH_HDR_FIRST;
      kind_nxt  = rffp_pkg::KIND_NONE;
    end
  end

  always_comb begin
    res_o.frame_kind      = (kind_r == rffp_pkg::KIND_FLOW);
    res_o.crc_ok          = ok;
    res_o.range_quality   = rqual_nxt;
    res_o.range_mm        = range_nxt;
    res_o.surface_quality = squal_nxt;
    res_o.motion_x        = mx_nxt;
    res_o.motion_y        = my_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rffp_pkg::PH_HDR_FIRST;
      kind_r  <= rffp_pkg::KIND_NONE;
      crc_r   <= 8'd0;
      range_r <= 32'd0;
      rqual_r <= 8'd0;
      squal_r <= 8'd0;
      mx_r    <= 32'd0;
      my_r    <= 32'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      crc_r   <= crc_nxt;
      range_r <= range_nxt;
      rqual_r <= rqual_nxt;
      squal_r <= squal_nxt;
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
    end
  end

  // payload capture, no reset
  always_ff @(posedge clk) begin
    if (step_en && st_we) begin
      store_r[st_off[IDX_W-1:0]] <= byte_i;
    end
  end

endmodule

@@ rtl/range_flow_frame_parser_core.sv @@
// Range / optical-flow frame parser, top level.
// A taken byte is held in the input register until parsed; each result is registered for out_*.
// Throughput: one byte per cycle; bytes that end no frame keep flowing while a result is stalled.
// Only a checksum byte waits in the input register while the output register is still held.
// Reset (rst_n low, synchronous): parser idle, held values zero, registers back to defaults.
// Depends on rffp_pkg and rffp_parser.
module range_flow_frame_parser_core #(
  parameter int unsigned PAYLOAD_DEPTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_frame_kind,
  output logic                          out_crc_ok,
  output logic [7:0]                    out_range_quality,
  output logic signed [31:0]            out_range_mm,
  output logic [7:0]                    out_surface_quality,
  output logic signed [31:0]            out_motion_x,
  output logic signed [31:0]            out_motion_y,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [rffp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                    cfg_wdata
);

  // config registers
  rffp_pkg::cfg_t cfg_r;

  // input register: doubles as the skid stage when a result is stuck
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_take;

  // output register
  logic           out_vld_r, out_vld_nxt;
  rffp_pkg::res_t out_res_r;

  // parser handshake
  logic           adv;
  logic           emit;
  rffp_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first   <= 8'd36;
      cfg_r.header_second  <= 8'd88;
      cfg_r.direction_byte <= 8'd60;
      cfg_r.flag_byte      <= 8'd0;
      cfg_r.range_id       <= 8'd1;
      cfg_r.flow_id        <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rffp_pkg::CFG_HEADER_FIRST:   cfg_r.header_first   <= cfg_wdata;
        rffp_pkg::CFG_HEADER_SECOND:  cfg_r.header_second  <= cfg_wdata;
        rffp_pkg::CFG_DIRECTION_BYTE: cfg_r.direction_byte <= cfg_wdata;
        rffp_pkg::CFG_FLAG_BYTE:      cfg_r.flag_byte      <= cfg_wdata;
        rffp_pkg::CFG_RANGE_ID:       cfg_r.range_id       <= cfg_wdata;
        rffp_pkg::CFG_FLOW_ID:        cfg_r.flow_id        <= cfg_wdata;
        default: ;  // unused index, dropped
      endcase
    end
  end

  rffp_parser #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .byte_i  (in_byte_r),
    .cfg_i   (cfg_r),
    .emit_o  (emit),
    .res_o   (res)
  );

  // The held byte moves into the parser unless it would produce a result
  // while the output register still holds one that is stalled.
  assign adv      = in_vld_r && (!emit || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_comb begin
    if (adv && emit) begin
      out_vld_nxt = 1'b1;
    end else begin
      out_vld_nxt = out_vld_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_frame_kind      = out_res_r.frame_kind;
  assign out_crc_ok          = out_res_r.crc_ok;
  assign out_range_quality   = out_res_r.range_quality;
  assign out_range_mm        = $signed(out_res_r.range_mm);
  assign out_surface_quality = out_res_r.surface_quality;
  assign out_motion_x        = $signed(out_res_r.motion_x);
  assign out_motion_y        = $signed(out_res_r.motion_y);

  // A new result never lands on top of a stalled one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !(adv && emit))
    else $error("result register overwritten while stalled");

  // The input side only stalls when a byte is actually held.
  a_stall_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && emit && out_vld_r))
    else $error("input stalled without a pending checksum byte");

  // A parsed checksum byte shows up as a result on the next cycle.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit) |=> out_vld_r)
    else $error("emitted result not presented");

endmodule

@@ bench/rffp_frame_checker.sv @@
// Scoreboard for range_flow_frame_parser_core: a parser model of its own, a result queue and a compare.
// Also holds rffp_tb_pkg (register defaults, the CRC-8 DVB-S2 byte step), which the bench top uses as well.
// Depends on rffp_pkg.
`timescale 1ns / 1ps

package rffp_tb_pkg;
  import rffp_pkg::*;

  localparam cfg_t REG_DEFAULTS = '{
    header_first:   8'd36,
    header_second:  8'd88,
    direction_byte: 8'd60,
    flag_byte:      8'd0,
    range_id:       8'd1,
    flow_id:        8'd2
  };

  // msb-first, polynomial from the design package
  function automatic logic [7:0] dvbs2_crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc ^ data;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction
endpackage

module rffp_frame_checker import rffp_pkg::*; import rffp_tb_pkg::*; #(
  parameter int unsigned PAYLOAD_DEPTH = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_frame_kind,
  input  logic                 out_crc_ok,
  input  logic [7:0]           out_range_quality,
  input  logic signed [31:0]   out_range_mm,
  input  logic [7:0]           out_surface_quality,
  input  logic signed [31:0]   out_motion_x,
  input  logic signed [31:0]   out_motion_y,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]           cfg_wdata,
  output int                   mismatch_count,
  output int                   frames_pending,
  output int                   frames_checked
);

  localparam int REPORT_LIMIT = 10;

  cfg_t       want;
  logic [4:0] phase;
  kind_t      kind;
  logic [7:0] crc;
  logic [7:0] payload [PAYLOAD_DEPTH];
  res_t       held;
  res_t       expected_q [$];

  int mismatches = 0;
  int pending    = 0;
  int checked    = 0;

  assign mismatch_count = mismatches;
  assign frames_pending = pending;
  assign frames_checked = checked;

  // Advance the parser model by one byte; returns 1 when the byte closes a frame.
  function automatic bit parse_byte(input logic [7:0] b, output res_t r);
    logic [7:0] hdr [4];
    logic [4:0] chk_phase;
    bit         ok;
    r = held;
    hdr = '{want.header_first, want.header_second, want.direction_byte, want.flag_byte};
    if (phase < PH_ID) begin
      if (b == hdr[phase[1:0]]) begin
        phase = phase + 5'd1;
      end else begin
        phase = PH_HDR_FIRST;
        kind  = KIND_NONE;
      end
      return 1'b0;
    end
    if (phase == PH_ID) begin
      // range wins when both ids are equal
      if (b == want.range_id) begin
        kind  = KIND_RANGE;
        crc   = CRC_PRESET_RANGE;
        phase = phase + 5'd1;
      end else if (b == want.flow_id) begin
        kind  = KIND_FLOW;
        crc   = CRC_PRESET_FLOW;
        phase = phase + 5'd1;
      end else begin
        phase = PH_HDR_FIRST;
        kind  = KIND_NONE;
      end
      return 1'b0;
    end
    if (kind == KIND_NONE) begin
      phase = PH_HDR_FIRST;
      return 1'b0;
    end
    chk_phase = (kind == KIND_RANGE) ? PH_CHK_RANGE : PH_CHK_FLOW;
    if (phase < chk_phase) begin
      payload[phase - PH_FIRST_DATA] = b;
      crc   = dvbs2_crc_byte(crc, b);
      phase = phase + 5'd1;
      return 1'b0;
    end
    if (phase != chk_phase) begin
      phase = PH_HDR_FIRST;
      kind  = KIND_NONE;
      return 1'b0;
    end
    ok = (crc == b);
    if (ok && kind == KIND_RANGE) begin
      held.range_quality = payload[3];
      held.range_mm      = {payload[7], payload[6], payload[5], payload[4]};
    end else if (ok) begin
      held.surface_quality = payload[3];
      held.motion_x        = {payload[7], payload[6], payload[5], payload[4]};
      held.motion_y        = {payload[11], payload[10], payload[9], payload[8]};
    end
    r = held;
    r.frame_kind = (kind == KIND_FLOW);
    r.crc_ok     = ok;
    phase = PH_HDR_FIRST;
    kind  = KIND_NONE;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    res_t exp_r;
    res_t got;
    bit   hit;
    if (!rst_n) begin
      want  = REG_DEFAULTS;
      phase = PH_HDR_FIRST;
      kind  = KIND_NONE;
      crc   = 8'd0;
      held  = '0;
      foreach (payload[i]) payload[i] = 8'd0;
      expected_q.delete();
    end else begin
      // the byte is judged against the registers as they were before this edge
      if (in_valid && !in_stall) begin
        hit = parse_byte(in_rx_byte, exp_r);
        if (hit) expected_q.push_back(exp_r);
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HEADER_FIRST:   want.header_first   = cfg_wdata;
          CFG_HEADER_SECOND:  want.header_second  = cfg_wdata;
          CFG_DIRECTION_BYTE: want.direction_byte = cfg_wdata;
          CFG_FLAG_BYTE:      want.flag_byte      = cfg_wdata;
          CFG_RANGE_ID:       want.range_id       = cfg_wdata;
          CFG_FLOW_ID:        want.flow_id        = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_frame_kind, out_crc_ok, out_range_quality, out_range_mm,
               out_surface_quality, out_motion_x, out_motion_y};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("ERROR %0t: result with nothing expected: %h", $realtime, got);
        end else begin
          exp_r = expected_q.pop_front();
          checked++;
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("ERROR %0t: result %0d differs", $realtime, checked);
              $display("  kind/ok  exp %0d/%0d  got %0d/%0d", exp_r.frame_kind,
                       exp_r.crc_ok, got.frame_kind, got.crc_ok);
              $display("  range    exp q=%h mm=%h  got q=%h mm=%h", exp_r.range_quality,
                       exp_r.range_mm, got.range_quality, got.range_mm);
              $display("  flow     exp q=%h x=%h y=%h  got q=%h x=%h y=%h",
                       exp_r.surface_quality, exp_r.motion_x, exp_r.motion_y,
                       got.surface_quality, got.motion_x, got.motion_y);
            end
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ bench/tb_range_flow_frame_parser_core.sv @@
// Bench top for range_flow_frame_parser_core: clock, reset, byte stimulus, stall pattern, verdict.
// Prediction and comparison sit in rffp_frame_checker; depends on rffp_pkg and rffp_tb_pkg.
`timescale 1ns / 1ps

module tb_range_flow_frame_parser_core;
  import rffp_pkg::*;
  import rffp_tb_pkg::*;

  localparam int PAYLOAD_DEPTH = 12;
  localparam int RANGE_BODY    = 8;
  localparam int FLOW_BODY     = 12;
  localparam int BYTE_GOAL     = 540;     // random part, input transactions (directed part ~200)
  localparam int DRAIN_LIMIT   = 5000;    // cycles allowed for the last results to come out
  localparam int TIMEOUT_NS    = 3000000; // far beyond the slowest legal run

  typedef logic [7:0] byte_q_t [$];
  typedef logic [7:0] body_t [FLOW_BODY];

  // receiver behavior, re-chosen at random when its run ends
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

  // body fill patterns
  typedef enum int {FILL_ZEROS, FILL_ONES, FILL_SIGN_EDGES, FILL_RANDOM} fill_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_frame_kind;
  logic                  out_crc_ok;
  logic [7:0]            out_range_quality;
  logic signed [31:0]    out_range_mm;
  logic [7:0]            out_surface_quality;
  logic signed [31:0]    out_motion_x;
  logic signed [31:0]    out_motion_y;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [7:0]            cfg_wdata;

  int mismatch_count;
  int frames_pending;
  int frames_checked;

  // what the bench believes the registers hold; used to build frames
  cfg_t hdr_cfg;

  int burst_left     = 0;
  int bytes_sent     = 0;
  int frame_attempts = 0;
  int reg_settings   = 1;

  range_flow_frame_parser_core #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_kind      (out_frame_kind),
    .out_crc_ok          (out_crc_ok),
    .out_range_quality   (out_range_quality),
    .out_range_mm        (out_range_mm),
    .out_surface_quality (out_surface_quality),
    .out_motion_x        (out_motion_x),
    .out_motion_y        (out_motion_y),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata)
  );

  rffp_frame_checker #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_frame_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_kind      (out_frame_kind),
    .out_crc_ok          (out_crc_ok),
    .out_range_quality   (out_range_quality),
    .out_range_mm        (out_range_mm),
    .out_surface_quality (out_surface_quality),
    .out_motion_x        (out_motion_x),
    .out_motion_y        (out_motion_y),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata),
    .mismatch_count      (mismatch_count),
    .frames_pending      (frames_pending),
    .frames_checked      (frames_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("ERROR: run timed out, %0d results still outstanding", frames_pending);
    $display("== FAIL ==");
    $finish;
  end

  // Result-side backpressure. Modes switch at random so stalls land on every
  // phase of the parser, including long free-flowing stretches.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 1) == 0);
      default:      out_stall <= ((stall_left % 8) < 5);
    endcase
  end

  // One byte transaction. The sender runs in bursts; between bursts it may
  // idle for a random gap (or not at all, which gives back-to-back bursts).
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    // in_stall read right after the edge holds its pre-edge value
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t f);
    foreach (f[i]) push_byte(f[i]);
  endtask

  // Stop sending, wait for every predicted result, then let the input
  // register and the parser finish with bytes that produce nothing.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  // Only called with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEADER_FIRST:   hdr_cfg.header_first   = val;
      CFG_HEADER_SECOND:  hdr_cfg.header_second  = val;
      CFG_DIRECTION_BYTE: hdr_cfg.direction_byte = val;
      CFG_FLAG_BYTE:      hdr_cfg.flag_byte      = val;
      CFG_RANGE_ID:       hdr_cfg.range_id       = val;
      CFG_FLOW_ID:        hdr_cfg.flow_id        = val;
      default: ;  // unmapped index, the block ignores it
    endcase
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(CFG_HEADER_FIRST,   c.header_first);
    write_reg(CFG_HEADER_SECOND,  c.header_second);
    write_reg(CFG_DIRECTION_BYTE, c.direction_byte);
    write_reg(CFG_FLAG_BYTE,      c.flag_byte);
    write_reg(CFG_RANGE_ID,       c.range_id);
    write_reg(CFG_FLOW_ID,        c.flow_id);
    reg_settings++;
  endtask

  // Random register churn between phases: extremes weighted up, the two
  // unmapped indexes included, and now and then both ids made equal.
  task automatic shuffle_regs();
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           val;
    repeat ($urandom_range(1, 4)) begin
      idx = CFG_IDX_W'($urandom_range(0, (1 << CFG_IDX_W) - 1));
      case ($urandom_range(0, 3))
        0:       val = 8'h00;
        1:       val = 8'hFF;
        default: val = 8'($urandom_range(0, 255));
      endcase
      write_reg(idx, val);
    end
    if ($urandom_range(0, 5) == 0) write_reg(CFG_FLOW_ID, hdr_cfg.range_id);
    reg_settings++;
  endtask

  // Payload contents. Entry 3 is the quality byte; entries 4..7 and 8..11
  // are the little-endian words.
  function automatic body_t make_body(input fill_t fill);
    body_t b;
    foreach (b[i]) b[i] = 8'($urandom_range(0, 255));
    case (fill)
      FILL_ZEROS: foreach (b[i]) b[i] = 8'h00;
      FILL_ONES:  foreach (b[i]) b[i] = 8'hFF;
      FILL_SIGN_EDGES: begin
        // most negative in the first word, most positive in the second
        {b[7], b[6], b[5], b[4]}   = 32'h8000_0000;
        {b[11], b[10], b[9], b[8]} = 32'h7FFF_FFFF;
      end
      default: ;
    endcase
    return b;
  endfunction

  // Complete frame under the current registers; spoil flips one checksum bit.
  function automatic byte_q_t build_frame(input bit flow, input body_t body, input bit spoil);
    byte_q_t    f;
    logic [7:0] crc;
    int         n;
    n   = flow ? FLOW_BODY : RANGE_BODY;
    crc = flow ? CRC_PRESET_FLOW : CRC_PRESET_RANGE;
    f   = '{hdr_cfg.header_first, hdr_cfg.header_second, hdr_cfg.direction_byte,
            hdr_cfg.flag_byte, flow ? hdr_cfg.flow_id : hdr_cfg.range_id};
    for (int i = 0; i < n; i++) begin
      f.push_back(body[i]);
      crc = dvbs2_crc_byte(crc, body[i]);
    end
    f.push_back(spoil ? crc ^ (8'd1 << $urandom_range(0, 7)) : crc);
    return f;
  endfunction

  task automatic send_frame(input bit flow, input fill_t fill, input bit spoil);
    frame_attempts++;
    send_bytes(build_frame(flow, make_body(fill), spoil));
  endtask

  initial begin
    byte_q_t f;
    cfg_t    c;
    int      rand_start;
    int      next_shuffle;
    int      pick;

    // every input known from time zero
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = 8'h00;
    hdr_cfg    = REG_DEFAULTS;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---------------- directed part ----------------
    // Reset defaults: range frame with all-ones payload (range -1, quality 255),
    // flow frame with the sign-boundary words, then a bad checksum.
    send_frame(1'b0, FILL_ONES, 1'b0);
    send_frame(1'b1, FILL_SIGN_EDGES, 1'b0);
    send_frame(1'b0, FILL_RANDOM, 1'b1);

    // First header byte twice: the repeat fails the second header compare,
    // the parser drops to idle and does not re-examine that byte, so the
    // rest of the frame is lost.
    push_byte(hdr_cfg.header_first);
    send_frame(1'b0, FILL_RANDOM, 1'b0);

    // Unknown id byte aborts the frame.
    f = build_frame(1'b1, make_body(FILL_RANDOM), 1'b0);
    f[4] = ~(hdr_cfg.range_id | hdr_cfg.flow_id);
    frame_attempts++;
    send_bytes(f);

    // Register change in the middle of a frame: three header bytes, pause,
    // new flag byte, then the frame continues under the new value.
    drain_pipeline();
    f = build_frame(1'b0, make_body(FILL_RANDOM), 1'b0);
    for (int i = 0; i < 3; i++) push_byte(f[i]);
    drain_pipeline();
    write_reg(CFG_FLAG_BYTE, 8'h5A);
    f = build_frame(1'b0, make_body(FILL_RANDOM), 1'b0);
    frame_attempts++;
    for (int i = 3; i < f.size(); i++) push_byte(f[i]);

    // Unmapped register indexes must be ignored.
    drain_pipeline();
    write_reg(CFG_FLOW_ID + 3'd1, 8'hA5);
    write_reg(CFG_FLOW_ID + 3'd2, 8'h3C);
    send_frame(1'b1, FILL_ZEROS, 1'b0);

    // All-ones headers, ids at opposite extremes.
    drain_pipeline();
    c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    load_regs(c);
    send_frame(1'b0, FILL_ZEROS, 1'b0);
    send_frame(1'b1, FILL_ONES, 1'b0);

    // All-zero headers, ids swapped.
    drain_pipeline();
    c = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00};
    load_regs(c);
    send_frame(1'b1, FILL_SIGN_EDGES, 1'b0);
    send_frame(1'b0, FILL_SIGN_EDGES, 1'b0);

    // Equal ids: the id selects a range frame, so a flow-built frame is cut
    // short at range length and normally fails its checksum.
    drain_pipeline();
    write_reg(CFG_FLOW_ID, hdr_cfg.range_id);
    send_frame(1'b0, FILL_RANDOM, 1'b0);
    send_frame(1'b1, FILL_RANDOM, 1'b0);

    drain_pipeline();
    load_regs(REG_DEFAULTS);

    // ---------------- random part ----------------
    // Mostly well-formed frames with random content; the rest are cut or
    // corrupted frames and loose noise bytes. Registers change between
    // phases, only with the block idle.
    rand_start    = bytes_sent;
    next_shuffle  = bytes_sent + $urandom_range(80, 160);
    while (bytes_sent - rand_start < BYTE_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(1'($urandom_range(0, 1)), fill_t'($urandom_range(0, 3) == 0 ?
                   $urandom_range(0, 2) : FILL_RANDOM), $urandom_range(0, 6) == 0);
      end else if (pick < 80) begin
        f = build_frame(1'($urandom_range(0, 1)), make_body(FILL_RANDOM), 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          // truncated: parser is left mid-frame and swallows what follows
          f = f[0 : $urandom_range(0, f.size() - 2)];
        end else begin
          // header or id byte damaged
          pick = $urandom_range(0, 4);
          f[pick] = f[pick] ^ 8'($urandom_range(1, 255));
        end
        frame_attempts++;
        send_bytes(f);
      end else begin
        repeat ($urandom_range(1, 6))
          push_byte(($urandom_range(0, 3) == 0) ? hdr_cfg.header_first
                                                  : 8'($urandom_range(0, 255)));
      end
      if (bytes_sent >= next_shuffle) begin
        drain_pipeline();
        shuffle_regs();
        next_shuffle = bytes_sent + $urandom_range(80, 160);
      end
    end

    // ---------------- wind-down ----------------
    @(negedge clk);
    in_valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && frames_pending != 0; w++) @(negedge clk);
    repeat (8) @(negedge clk);

    if (frames_pending != 0)
      $display("ERROR: %0d expected results never came out", frames_pending);
    $display("Covered %0d byte transactions in %0d frame attempts over %0d register settings",
             bytes_sent, frame_attempts, reg_settings);
    $display("Compared %0d results, %0d mismatches", frames_checked, mismatch_count);
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
